// ----- design/ftc_pkg.sv -----
// Shared constants, codes and types of the four-point touch calibration core.
package ftc_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLES_PER_POINT_DEF = 4;
    localparam int COORD_BITS_DEF        = 10;
    localparam int COORD_BITS_MAX        = 16;

    // Field and register widths
    localparam int SCALE_W     = 12;
    localparam int THRESH_W    = 11;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int RESULT_W    = 16;

    // Queue item data words are sized for the widest sum any legal setting can produce
    localparam int ITEM_W      = COORD_BITS_MAX + 5;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_THRESHOLD = 2'd2;

    // Configuration reset values
    localparam logic [SCALE_W-1:0]  SCREEN_WIDTH_RST     = 12'd1024;
    localparam logic [SCALE_W-1:0]  SCREEN_HEIGHT_RST    = 12'd768;
    localparam logic [THRESH_W-1:0] REPEAT_THRESHOLD_RST = 11'd10;

    // Work classes handed from the front to the back
    typedef enum logic [1:0] {
        OP_REJECT,
        OP_ACCEPT,
        OP_CAPTURE,
        OP_MAP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITEM_W-1:0] a;
        logic [ITEM_W-1:0] b;
    } queue_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_x;
        logic signed [RESULT_W-1:0] result_y;
        logic                       sample_accepted;
        logic                       point_captured;
        logic                       calibration_done;
        logic                       map_error;
    } result_t;

endpackage

// ----- design/ftc_if.sv -----
// Channel interfaces of the four-point touch calibration core.
interface ftc_point_if #(
    parameter int COORD_BITS = ftc_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, command, point_x, point_y, input ready);
    modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

interface ftc_result_if ();
    logic                                valid;
    logic                                ready;
    logic signed [ftc_pkg::RESULT_W-1:0] result_x;
    logic signed [ftc_pkg::RESULT_W-1:0] result_y;
    logic                                sample_accepted;
    logic                                point_captured;
    logic                                calibration_done;
    logic                                map_error;

    modport source (output valid, result_x, result_y, sample_accepted, point_captured,
                    calibration_done, map_error, input ready);
    modport sink   (input valid, result_x, result_y, sample_accepted, point_captured,
                    calibration_done, map_error, output ready);
endinterface

// ----- design/ftc_front.sv -----
// Front end: repeat filter and sample accumulator, classifies each transfer for the back end.
module ftc_front #(
    parameter int SAMPLES_PER_POINT = ftc_pkg::SAMPLES_PER_POINT_DEF,
    parameter int COORD_BITS        = ftc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ftc_point_if.sink                     sample_in,
    input  logic [ftc_pkg::THRESH_W-1:0]  repeat_threshold,
    input  logic                          queue_full,
    output logic                          push,
    output ftc_pkg::queue_item_t          item
);
    import ftc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_POINT + 1);
    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int CMP_W = (COORD_BITS + 1 > THRESH_W) ? COORD_BITS + 1 : THRESH_W;

    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]      sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [COORD_BITS-1:0] diff_x;
    logic [COORD_BITS-1:0] diff_y;
    logic [CMP_W-1:0]      manhattan;
    logic                  is_repeat;
    logic [SUM_W-1:0]      sum_x_add;
    logic [SUM_W-1:0]      sum_y_add;
    logic [CNT_W-1:0]      count_inc;
    logic                  capture;

    // Accept whenever the queue has room
    assign sample_in.ready = !queue_full;
    assign push            = sample_in.valid && !queue_full;

    // Manhattan distance to the last accepted sample
    assign diff_x = (last_x_reg > sample_in.point_x) ? last_x_reg - sample_in.point_x
                                                      : sample_in.point_x - last_x_reg;
    assign diff_y = (last_y_reg > sample_in.point_y) ? last_y_reg - sample_in.point_y
                                                      : sample_in.point_y - last_y_reg;
    assign manhattan = CMP_W'(diff_x) + CMP_W'(diff_y);

    // A sample close to a nonzero last sample is a repeat
    assign is_repeat = (manhattan < CMP_W'(repeat_threshold))
                    && (last_x_reg != '0 || last_y_reg != '0);

    assign sum_x_add = sum_x_reg + SUM_W'(sample_in.point_x);
    assign sum_y_add = sum_y_reg + SUM_W'(sample_in.point_y);
    assign count_inc = count_reg + CNT_W'(1);
    assign capture   = (count_inc == CNT_W'(SAMPLES_PER_POINT));

    // Classify the transfer
    always_comb
    begin
        item.a = ITEM_W'(sample_in.point_x);
        item.b = ITEM_W'(sample_in.point_y);
        if (sample_in.command)
        begin
            item.op = OP_MAP;
        end
        else if (is_repeat)
        begin
            item.op = OP_REJECT;
        end
        else if (capture)
        begin
            item.op = OP_CAPTURE;
            item.a  = ITEM_W'(sum_x_add);
            item.b  = ITEM_W'(sum_y_add);
        end
        else
        begin
            item.op = OP_ACCEPT;
        end
    end

    // Advance the accumulator on an accepted sample
    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        count_next  = count_reg;
        if (push && !sample_in.command && !is_repeat)
        begin
            last_x_next = sample_in.point_x;
            last_y_next = sample_in.point_y;
            if (capture)
            begin
                sum_x_next = '0;
                sum_y_next = '0;
                count_next = '0;
            end
            else
            begin
                sum_x_next = sum_x_add;
                sum_y_next = sum_y_add;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(SAMPLES_PER_POINT))
        else $error("sample count out of range");

    a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && item.op == OP_CAPTURE) |=> (count_reg == '0 && sum_x_reg == '0
                                             && sum_y_reg == '0))
        else $error("accumulator not cleared after a corner capture");

endmodule

// ----- design/ftc_queue.sv -----
// Short queue of classified items between the front and the back end.
module ftc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ftc_pkg::queue_item_t item_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output ftc_pkg::queue_item_t item_out
);
    import ftc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign item_out = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- design/ftc_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module ftc_divider #(
    parameter int DIVIDEND_W = ftc_pkg::COORD_BITS_DEF + 13,
    parameter int DIVISOR_W  = ftc_pkg::COORD_BITS_DEF + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    // Trial subtract of the shifted remainder
    assign rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = !trial[DIVISOR_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[DIVISOR_W:0] : rem_shift;
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/ftc_back.sv -----
// Back end: corner averaging, span calculation, point mapping and the output register.
module ftc_back #(
    parameter int SAMPLES_PER_POINT = ftc_pkg::SAMPLES_PER_POINT_DEF,
    parameter int COORD_BITS        = ftc_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ftc_pkg::SCALE_W-1:0]   screen_width,
    input  logic [ftc_pkg::SCALE_W-1:0]   screen_height,
    input  logic                          queue_empty,
    input  ftc_pkg::queue_item_t          head,
    output logic                          pop,
    ftc_result_if.source                  result_out
);
    import ftc_pkg::*;

    localparam int CNT_W  = $clog2(SAMPLES_PER_POINT + 1);
    localparam int SUM_W  = COORD_BITS + CNT_W;
    localparam int SPAN_W = COORD_BITS + 1;
    localparam int NUM_W  = COORD_BITS + 3;
    localparam int PROD_W = NUM_W + SCALE_W + 1;
    localparam int DIV_DW = COORD_BITS + 13;
    localparam int DIV_VW = COORD_BITS + 2;

    // Rounded mean (2 * sum + n) / (2 * n) by a reciprocal multiply, exact over CAP_W bits
    localparam int CAP_W  = SUM_W + 1;
    localparam int CAP_D  = 2 * SAMPLES_PER_POINT;
    localparam int CAP_S  = CAP_W + $clog2(CAP_D);
    localparam int CAP_MW = CAP_W + 1;
    localparam int CAP_PW = CAP_W + CAP_MW;
    localparam logic [CAP_MW-1:0] CAP_RECIP = CAP_MW'(((1 << CAP_S) + CAP_D - 1) / CAP_D);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SPAN  = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [COORD_BITS-1:0]       px_reg, px_next;
    logic [COORD_BITS-1:0]       py_reg, py_next;
    logic [3:0][COORD_BITS-1:0]  corner_x_reg, corner_x_next;
    logic [3:0][COORD_BITS-1:0]  corner_y_reg, corner_y_next;
    logic [1:0]                  idx_reg, idx_next;
    logic signed [SPAN_W-1:0]    span_w_reg, span_w_next;
    logic signed [SPAN_W-1:0]    span_h_reg, span_h_next;
    logic                        calibrated_reg, calibrated_next;
    logic signed [PROD_W-1:0]    prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]    prod_y_reg, prod_y_next;
    logic                        neg_x_reg, neg_x_next;
    logic                        neg_y_reg, neg_y_next;
    result_t                     res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    result_t                     out_data_reg, out_data_next;

    logic                        div_start;
    logic [DIV_DW-1:0]           dividend_x, dividend_y;
    logic [DIV_VW-1:0]           divisor_x, divisor_y;
    logic                        busy_x, busy_y;
    logic                        done_x, done_y;
    logic [DIV_DW-1:0]           quo_x, quo_y;

    logic signed [NUM_W-1:0]     num_x, num_y;
    logic [PROD_W-1:0]           prod_mag_x, prod_mag_y;
    logic signed [DIV_VW-1:0]    span2_h, span2_w;
    logic [DIV_VW-1:0]           span_mag_h, span_mag_w;
    logic [CAP_W-1:0]            cap_num_x, cap_num_y;
    logic [CAP_PW-1:0]           cap_prod_x, cap_prod_y;
    logic [COORD_BITS-1:0]       avg_x, avg_y;
    logic signed [SPAN_W:0]      h_sum, w_sum;
    logic signed [SPAN_W:0]      h_adj, w_adj;
    logic [RESULT_W:0]           sat_x, sat_y;

    // Clamp a signed quotient given as magnitude and sign; returns {error, value}
    function automatic logic [RESULT_W:0] saturate(input logic [DIV_DW-1:0] mag,
                                                    input logic neg);
        logic [RESULT_W:0] r;
        if (neg)
        begin
            if (mag > DIV_DW'(32768))
            begin
                r = {1'b1, 1'b1, {(RESULT_W-1){1'b0}}};
            end
            else
            begin
                r = {1'b0, RESULT_W'(0) - mag[RESULT_W-1:0]};
            end
        end
        else
        begin
            if (mag > DIV_DW'(32767))
            begin
                r = {1'b1, 1'b0, {(RESULT_W-1){1'b1}}};
            end
            else
            begin
                r = {1'b0, mag[RESULT_W-1:0]};
            end
        end
        return r;
    endfunction

    // Mapping numerators with swapped axes
    assign num_x = $signed({2'b00, py_reg, 1'b0}) - $signed({3'b000, corner_y_reg[0]})
                 - $signed({3'b000, corner_y_reg[3]});
    assign num_y = $signed({3'b000, corner_x_reg[0]}) + $signed({3'b000, corner_x_reg[1]})
                 - $signed({2'b00, px_reg, 1'b0});

    assign prod_mag_x = prod_x_reg[PROD_W-1] ? $unsigned(-prod_x_reg) : $unsigned(prod_x_reg);
    assign prod_mag_y = prod_y_reg[PROD_W-1] ? $unsigned(-prod_y_reg) : $unsigned(prod_y_reg);

    assign span2_h    = {span_h_reg, 1'b0};
    assign span2_w    = {span_w_reg, 1'b0};
    assign span_mag_h = span2_h[DIV_VW-1] ? $unsigned(-span2_h) : $unsigned(span2_h);
    assign span_mag_w = span2_w[DIV_VW-1] ? $unsigned(-span2_w) : $unsigned(span2_w);

    // Rounded mean of the corner samples, half up
    assign cap_num_x  = {head.a[SUM_W-1:0], 1'b0} + CAP_W'(SAMPLES_PER_POINT);
    assign cap_num_y  = {head.b[SUM_W-1:0], 1'b0} + CAP_W'(SAMPLES_PER_POINT);
    assign cap_prod_x = CAP_PW'(cap_num_x) * CAP_PW'(CAP_RECIP);
    assign cap_prod_y = CAP_PW'(cap_num_y) * CAP_PW'(CAP_RECIP);
    assign avg_x      = cap_prod_x[CAP_S +: COORD_BITS];
    assign avg_y      = cap_prod_y[CAP_S +: COORD_BITS];

    // Spans from the four corners, halved toward zero
    assign h_sum = $signed({2'b00, corner_y_reg[1]}) - $signed({2'b00, corner_y_reg[0]})
                 + $signed({2'b00, corner_y_reg[2]}) - $signed({2'b00, corner_y_reg[3]});
    assign w_sum = $signed({2'b00, corner_x_reg[0]}) - $signed({2'b00, corner_x_reg[3]})
                 + $signed({2'b00, corner_x_reg[1]}) - $signed({2'b00, corner_x_reg[2]});
    assign h_adj = h_sum + $signed({{SPAN_W{1'b0}}, h_sum[SPAN_W]});
    assign w_adj = w_sum + $signed({{SPAN_W{1'b0}}, w_sum[SPAN_W]});

    assign sat_x = saturate(quo_x, neg_x_reg);
    assign sat_y = saturate(quo_y, neg_y_reg);

    ftc_divider #(
        .DIVIDEND_W (DIV_DW),
        .DIVISOR_W  (DIV_VW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_x),
        .divisor  (divisor_x),
        .busy     (busy_x),
        .done     (done_x),
        .quotient (quo_x)
    );

    ftc_divider #(
        .DIVIDEND_W (DIV_DW),
        .DIVISOR_W  (DIV_VW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_y),
        .divisor  (divisor_y),
        .busy     (busy_y),
        .done     (done_y),
        .quotient (quo_y)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        corner_x_next   = corner_x_reg;
        corner_y_next   = corner_y_reg;
        idx_next        = idx_reg;
        span_w_next     = span_w_reg;
        span_h_next     = span_h_reg;
        calibrated_next = calibrated_reg;
        prod_x_next     = prod_x_reg;
        prod_y_next     = prod_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        dividend_x      = '0;
        dividend_y      = '0;
        divisor_x       = '0;
        divisor_y       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop      = 1'b1;
                    px_next  = head.a[COORD_BITS-1:0];
                    py_next  = head.b[COORD_BITS-1:0];
                    res_next = '0;
                    case (head.op)
                        OP_REJECT:
                        begin
                            state_next = ST_HOLD;
                        end
                        OP_ACCEPT:
                        begin
                            res_next.sample_accepted = 1'b1;
                            state_next               = ST_HOLD;
                        end
                        OP_CAPTURE:
                        begin
                            corner_x_next[idx_reg]   = avg_x;
                            corner_y_next[idx_reg]   = avg_y;
                            res_next.result_x        = RESULT_W'(avg_x);
                            res_next.result_y        = RESULT_W'(avg_y);
                            res_next.sample_accepted = 1'b1;
                            res_next.point_captured  = 1'b1;
                            idx_next                 = idx_reg + 2'd1;
                            state_next               = (idx_reg == 2'd3) ? ST_SPAN : ST_HOLD;
                        end
                        OP_MAP:
                        begin
                            if (calibrated_reg)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                res_next.result_x = RESULT_W'(head.a[COORD_BITS-1:0]);
                                res_next.result_y = RESULT_W'(head.b[COORD_BITS-1:0]);
                                state_next        = ST_HOLD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                prod_x_next = num_x * $signed({1'b0, screen_width});
                prod_y_next = num_y * $signed({1'b0, screen_height});
                state_next  = ST_START;
            end

            ST_START:
            begin
                div_start  = 1'b1;
                dividend_x = prod_mag_x[DIV_DW-1:0];
                dividend_y = prod_mag_y[DIV_DW-1:0];
                divisor_x  = span_mag_h;
                divisor_y  = span_mag_w;
                neg_x_next = prod_x_reg[PROD_W-1] ^ span_h_reg[SPAN_W-1];
                neg_y_next = prod_y_reg[PROD_W-1] ^ span_w_reg[SPAN_W-1];
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (done_x)
                begin
                    // A zero span gives zero on its axis and flags the error
                    res_next.map_error = 1'b0;
                    if (span_h_reg == '0)
                    begin
                        res_next.result_x  = '0;
                        res_next.map_error = 1'b1;
                    end
                    else
                    begin
                        res_next.result_x = sat_x[RESULT_W-1:0];
                        if (sat_x[RESULT_W])
                        begin
                            res_next.map_error = 1'b1;
                        end
                    end
                    if (span_w_reg == '0)
                    begin
                        res_next.result_y  = '0;
                        res_next.map_error = 1'b1;
                    end
                    else
                    begin
                        res_next.result_y = sat_y[RESULT_W-1:0];
                        if (sat_y[RESULT_W])
                        begin
                            res_next.map_error = 1'b1;
                        end
                    end
                    state_next = ST_HOLD;
                end
            end

            ST_SPAN:
            begin
                span_h_next               = h_adj[SPAN_W:1];
                span_w_next               = w_adj[SPAN_W:1];
                calibrated_next           = 1'b1;
                res_next.calibration_done = 1'b1;
                state_next                = ST_HOLD;
            end

            ST_HOLD:
            begin
                // Load the output register once it is free or being drained
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            corner_x_reg   <= '0;
            corner_y_reg   <= '0;
            idx_reg        <= '0;
            span_w_reg     <= '0;
            span_h_reg     <= '0;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            corner_x_reg   <= corner_x_next;
            corner_y_reg   <= corner_y_next;
            idx_reg        <= idx_next;
            span_w_reg     <= span_w_next;
            span_h_reg     <= span_h_next;
            calibrated_reg <= calibrated_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        prod_x_reg   <= prod_x_next;
        prod_y_reg   <= prod_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.result_x         = out_data_reg.result_x;
    assign result_out.result_y         = out_data_reg.result_y;
    assign result_out.sample_accepted  = out_data_reg.sample_accepted;
    assign result_out.point_captured   = out_data_reg.point_captured;
    assign result_out.calibration_done = out_data_reg.calibration_done;
    assign result_out.map_error        = out_data_reg.map_error;

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (busy_x || done_x))
        else $error("waiting on a divider that is not running");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (done_x == done_y) && (busy_x == busy_y))
        else $error("divider lanes out of step");

    a_done_with_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.calibration_done)
            |-> (out_data_reg.point_captured && out_data_reg.sample_accepted
                 && !out_data_reg.map_error))
        else $error("calibration done without a captured corner");

endmodule

// ----- design/four_point_touch_calibration_core.sv -----
// Top level of the four-point touch calibration core: configuration registers and wiring.
//
//  Channel      Direction  Handshake      Payload
//  sample_in    in         valid/ready    command, point_x, point_y
//  result_out   out        valid/ready    result_x, result_y, sample_accepted,
//                                         point_captured, calibration_done, map_error
//  cfg          in         cfg_we         cfg_index, cfg_data (write only)
//
//  Each input transfer is registered in the queue before the back end takes it. Rejected
//  and plain accepted samples, corner captures and map commands before calibration pass
//  the idle and hold states, the fourth corner also the span state. A calibrated map also
//  passes the multiply, start and divide states, the last waiting on the bit-serial
//  dividers, one for each axis. Reset is asynchronous and active low; it clears the
//  corners, spans and control state. The front keeps taking transfers into a two-entry
//  queue until it is full while the back end or the output register stalls.
module four_point_touch_calibration_core #(
    parameter int SAMPLES_PER_POINT = ftc_pkg::SAMPLES_PER_POINT_DEF,
    parameter int COORD_BITS        = ftc_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ftc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ftc_pkg::CFG_DATA_W-1:0]  cfg_data,
    ftc_point_if.sink                       sample_in,
    ftc_result_if.source                    result_out
);
    import ftc_pkg::*;

    logic [SCALE_W-1:0]  screen_width_reg, screen_width_next;
    logic [SCALE_W-1:0]  screen_height_reg, screen_height_next;
    logic [THRESH_W-1:0] threshold_reg, threshold_next;

    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    queue_item_t front_item;
    queue_item_t head_item;

    // Configuration writes; unknown indexes are dropped
    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        threshold_next     = threshold_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:     screen_width_next  = cfg_data[SCALE_W-1:0];
                CFG_SCREEN_HEIGHT:    screen_height_next = cfg_data[SCALE_W-1:0];
                CFG_REPEAT_THRESHOLD: threshold_next     = cfg_data[THRESH_W-1:0];
                default:              threshold_next     = threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            threshold_reg     <= REPEAT_THRESHOLD_RST;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            threshold_reg     <= threshold_next;
        end
    end

    ftc_front #(
        .SAMPLES_PER_POINT (SAMPLES_PER_POINT),
        .COORD_BITS        (COORD_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_in        (sample_in),
        .repeat_threshold (threshold_reg),
        .queue_full       (queue_full),
        .push             (push),
        .item             (front_item)
    );

    ftc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .item_out (head_item)
    );

    ftc_back #(
        .SAMPLES_PER_POINT (SAMPLES_PER_POINT),
        .COORD_BITS        (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .queue_empty   (queue_empty),
        .head          (head_item),
        .pop           (pop),
        .result_out    (result_out)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the four-point touch calibration core.
module tb_top;
    import ftc_pkg::*;

    localparam int CB            = COORD_BITS_DEF;
    localparam int SPP           = SAMPLES_PER_POINT_DEF;
    localparam int COORD_MAX     = (1 << CB) - 1;
    localparam int SETTLE_CYCLES = CB + 20;
    localparam int RUN_LIMIT     = 2_500_000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_MAP    = 1'b1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ftc_point_if #(.COORD_BITS(CB)) sample_ch ();
    ftc_result_if                   result_ch ();

    four_point_touch_calibration_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_ch),
        .result_out (result_ch)
    );

    always #2 clk = ~clk;

    // Predicted calibration state and register copies
    int unsigned scr_w      = SCREEN_WIDTH_RST;
    int unsigned scr_h      = SCREEN_HEIGHT_RST;
    int unsigned rep_thresh = REPEAT_THRESHOLD_RST;
    int unsigned acc_x, acc_y, acc_n, next_corner;
    int unsigned corner_x [4];
    int unsigned corner_y [4];
    int unsigned prev_x, prev_y;
    int          span_w, span_h;
    bit          calibrated;

    // Corners aimed at by the calibration rounds
    int unsigned quad_x [4];
    int unsigned quad_y [4];

    result_t     due_results [$];
    int          fail_count;
    int          items_sent;
    bit          sender_calm;
    bit          sink_calm;

    // Scale one axis by screen size over twice the span; clamp to 16 bits signed
    function automatic logic signed [RESULT_W-1:0] scale_axis(input longint num,
                                                              input int unsigned scale,
                                                              input int span, inout bit err);
        longint q;
        if (span == 0)
        begin
            err = 1'b1;
            return '0;
        end
        q = (num * longint'(scale)) / (longint'(span) * 2);
        if (q > 32767)
        begin
            q = 32767;
            err = 1'b1;
        end
        if (q < -32768)
        begin
            q = -32768;
            err = 1'b1;
        end
        return q[RESULT_W-1:0];
    endfunction

    // Advance the predicted state by one transfer and return the result it causes
    function automatic result_t touch_response(input logic cmd, input logic [CB-1:0] px,
                                               input logic [CB-1:0] py);
        result_t     r;
        int unsigned ux, uy, spread, cx, cy;
        int          hs, ws;
        longint      ny, nx;
        bit          err;
        r  = '0;
        ux = px;
        uy = py;
        err = 1'b0;
        if (cmd == CMD_SAMPLE)
        begin
            spread = ((prev_x > ux) ? prev_x - ux : ux - prev_x)
                   + ((prev_y > uy) ? prev_y - uy : uy - prev_y);
            // drop a repeat close to the last kept sample, unless that was the origin
            if (spread < rep_thresh && (prev_x != 0 || prev_y != 0))
                return r;
            r.sample_accepted = 1'b1;
            acc_x  += ux;
            acc_y  += uy;
            acc_n  += 1;
            prev_x = ux;
            prev_y = uy;
            if (acc_n >= SPP)
            begin
                // round half up to the averaged corner
                cx = ((2 * acc_x + SPP) / (2 * SPP)) & COORD_MAX;
                cy = ((2 * acc_y + SPP) / (2 * SPP)) & COORD_MAX;
                corner_x[next_corner] = cx;
                corner_y[next_corner] = cy;
                r.result_x       = cx[RESULT_W-1:0];
                r.result_y       = cy[RESULT_W-1:0];
                r.point_captured = 1'b1;
                acc_x = 0;
                acc_y = 0;
                acc_n = 0;
                next_corner = (next_corner + 1) % 4;
                if (next_corner == 0)
                begin
                    hs = (int'(corner_y[1]) - int'(corner_y[0]))
                       + (int'(corner_y[2]) - int'(corner_y[3]));
                    ws = (int'(corner_x[0]) - int'(corner_x[3]))
                       + (int'(corner_x[1]) - int'(corner_x[2]));
                    span_h = hs / 2;
                    span_w = ws / 2;
                    calibrated = 1'b1;
                    r.calibration_done = 1'b1;
                end
            end
            return r;
        end
        if (!calibrated)
        begin
            r.result_x = RESULT_W'(ux);
            r.result_y = RESULT_W'(uy);
            return r;
        end
        // swapped axes: screen x follows camera y, screen y follows camera x
        ny = 2 * longint'(uy) - longint'(corner_y[0]) - longint'(corner_y[3]);
        nx = longint'(corner_x[0]) + longint'(corner_x[1]) - 2 * longint'(ux);
        r.result_x  = scale_axis(ny, scr_w, span_h, err);
        r.result_y  = scale_axis(nx, scr_h, span_w, err);
        r.map_error = err;
        return r;
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [CB-1:0] pick_coord();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(0, 1) ? CB'(COORD_MAX) : '0;
        return CB'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic logic [CB-1:0] near(input int unsigned centre, input int unsigned reach);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * reach)) - int'(reach);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[CB-1:0];
    endfunction

    // Offer one item and hold it until the transfer; record what it should cause
    task automatic send_point(input logic cmd, input logic [CB-1:0] px,
                              input logic [CB-1:0] py);
        int   gap;
        logic hit;
        gap = draw_gap(sender_calm);
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.command <= cmd;
        sample_ch.point_x <= px;
        sample_ch.point_y <= py;
        do
        begin
            @(negedge clk);
            hit = (sample_ch.ready === 1'b1);
            @(posedge clk);
        end
        while (!hit);
        due_results.push_back(touch_response(cmd, px, py));
        items_sent++;
    endtask

    // Hold the sender until every expected result is back, then let the block go quiet
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:     scr_w = val & 12'hFFF;
            CFG_SCREEN_HEIGHT:    scr_h = val & 12'hFFF;
            CFG_REPEAT_THRESHOLD: rep_thresh = val & 11'h7FF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Aim up to eight samples at the corner due next, stopping early once it is captured
    task automatic send_corner_round();
        int unsigned slot, reach, tries;
        int          side_x, side_y, lo_x, lo_y;
        if (next_corner == 0 && acc_n == 0)
        begin
            // choose a fresh set of corners: an upright rectangle, tiny or wide, or any four
            if ($urandom_range(0, 2) != 0)
            begin
                side_x = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(40, 700);
                side_y = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(40, 700);
                lo_x = $urandom_range(0, COORD_MAX - side_x);
                lo_y = $urandom_range(0, COORD_MAX - side_y);
                quad_x[0] = lo_x + side_x;
                quad_y[0] = lo_y;
                quad_x[1] = lo_x + side_x;
                quad_y[1] = lo_y + side_y;
                quad_x[2] = lo_x;
                quad_y[2] = lo_y + side_y;
                quad_x[3] = lo_x;
                quad_y[3] = lo_y;
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    quad_x[i] = $urandom_range(0, COORD_MAX);
                    quad_y[i] = $urandom_range(0, COORD_MAX);
                end
            end
        end
        slot = next_corner;
        case ($urandom_range(0, 3))
            0:       reach = 0;
            1:       reach = 3;
            2:       reach = rep_thresh + 4;
            default: reach = 60;
        endcase
        tries = 0;
        do
        begin
            if ($urandom_range(0, 4) == 0)
                send_point(CMD_MAP, pick_coord(), pick_coord());
            send_point(CMD_SAMPLE, near(quad_x[slot], reach), near(quad_y[slot], reach));
            tries++;
        end
        while (next_corner == slot && tries < 8);
    endtask

    task automatic test_passthrough();
        send_point(CMD_MAP, '0, '0);
        send_point(CMD_MAP, CB'(COORD_MAX), CB'(COORD_MAX));
        send_point(CMD_MAP, CB'(10'h2AA), CB'(10'h155));
    endtask

    task automatic test_repeat_filter();
        // the origin is kept, and so is the next sample, because the last kept one is the origin
        send_point(CMD_SAMPLE, '0, '0);
        send_point(CMD_SAMPLE, CB'(3), CB'(3));
        // both of these fall inside the default threshold
        send_point(CMD_SAMPLE, CB'(5), CB'(6));
        send_point(CMD_SAMPLE, CB'(3), CB'(3));
    endtask

    task automatic test_corner_capture();
        settle();
        write_reg(CFG_REPEAT_THRESHOLD, 0);
        // finish the first corner with the largest coordinates
        send_point(CMD_SAMPLE, CB'(COORD_MAX), CB'(COORD_MAX));
        send_point(CMD_SAMPLE, CB'(COORD_MAX), CB'(COORD_MAX));
        // second corner lands half-way between two values and rounds up
        send_point(CMD_SAMPLE, CB'(512), CB'(512));
        send_point(CMD_SAMPLE, CB'(512), CB'(512));
        send_point(CMD_SAMPLE, CB'(513), CB'(512));
        send_point(CMD_SAMPLE, CB'(513), CB'(512));
        // last two corners leave zero height and a width of one
        repeat (4) send_point(CMD_SAMPLE, CB'(511), CB'(512));
        repeat (4) send_point(CMD_SAMPLE, CB'(512), CB'(512));
    endtask

    task automatic test_map_limits();
        // zero height: x flags an error while y is still scaled
        send_point(CMD_MAP, CB'(512), CB'(512));
        settle();
        write_reg(CFG_SCREEN_WIDTH, 4095);
        write_reg(CFG_SCREEN_HEIGHT, 4095);
        // a one-pixel width drives y into both saturation limits
        send_point(CMD_MAP, '0, '0);
        send_point(CMD_MAP, CB'(COORD_MAX), CB'(COORD_MAX));
    endtask

    task automatic test_random_traffic();
        int plan_w [9] = '{1, 4095, 640, -1, -1, -1, -1, 4095, 1};
        int plan_h [9] = '{1, 4095, 480, -1, -1, -1, -1, 1, 4095};
        int plan_t [9] = '{0, 2047, 25, -1, -1, -1, -1, 5, 120};
        int budget, start, pick;
        for (int p = 0; p < 9; p++)
        begin
            settle();
            write_reg(CFG_SCREEN_WIDTH, plan_w[p] < 0 ? $urandom_range(1, 4095) : plan_w[p]);
            write_reg(CFG_SCREEN_HEIGHT, plan_h[p] < 0 ? $urandom_range(1, 4095) : plan_h[p]);
            write_reg(CFG_REPEAT_THRESHOLD, plan_t[p] < 0 ? $urandom_range(0, 80) : plan_t[p]);
            budget = (rep_thresh > 1000) ? 60 : 200;
            start  = items_sent;
            while (items_sent - start < budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_corner_round();
                else if (pick < 72)
                    send_point(CMD_MAP, pick_coord(), pick_coord());
                else if (pick < 88)
                    // straddle the repeat threshold around the last kept sample
                    send_point(CMD_SAMPLE, near(prev_x, rep_thresh + 2),
                               near(prev_y, rep_thresh + 2));
                else if (pick < 97)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_point(CMD_SAMPLE, '0, '0);
                    else
                        send_point(CMD_SAMPLE, pick_coord(), pick_coord());
                end
                else
                    settle();
            end
        end
    endtask

    // Take results with random stalls and check each against the oldest prediction
    initial
    begin : result_sink
        result_t want;
        int      stall;
        logic    hit;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(sink_calm);
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                hit = (result_ch.valid === 1'b1);
                if (hit)
                begin
                    if (due_results.size() == 0)
                    begin
                        if (fail_count < 10)
                            $display("unexpected result: x=%0d y=%0d", result_ch.result_x,
                                     result_ch.result_y);
                        fail_count++;
                    end
                    else
                    begin
                        want = due_results.pop_front();
                        if (result_ch.result_x !== want.result_x ||
                            result_ch.result_y !== want.result_y ||
                            result_ch.sample_accepted !== want.sample_accepted ||
                            result_ch.point_captured !== want.point_captured ||
                            result_ch.calibration_done !== want.calibration_done ||
                            result_ch.map_error !== want.map_error)
                        begin
                            if (fail_count < 10)
                                $display("wrong result: expected x=%0d y=%0d acc=%b cap=%b cal=%b err=%b, got x=%0d y=%0d acc=%b cap=%b cal=%b err=%b",
                                         want.result_x, want.result_y, want.sample_accepted,
                                         want.point_captured, want.calibration_done,
                                         want.map_error, result_ch.result_x,
                                         result_ch.result_y, result_ch.sample_accepted,
                                         result_ch.point_captured, result_ch.calibration_done,
                                         result_ch.map_error);
                            fail_count++;
                        end
                    end
                end
                @(posedge clk);
            end
            while (!hit);
        end
    end

    // Stop a run that hangs
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("four_point_touch_calibration_core: mismatch");
        $finish;
    end

    initial
    begin
        sample_ch.valid   = 1'b0;
        sample_ch.command = CMD_SAMPLE;
        sample_ch.point_x = '0;
        sample_ch.point_y = '0;
        result_ch.ready   = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_SCREEN_WIDTH;
        cfg_data          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_repeat_filter();
        test_corner_capture();
        test_map_limits();
        test_random_traffic();
        settle();
        if (fail_count == 0)
            $display("four_point_touch_calibration_core: match");
        else
            $display("four_point_touch_calibration_core: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ftc_pkg.sv
design/ftc_if.sv
design/ftc_front.sv
design/ftc_queue.sv
design/ftc_divider.sv
design/ftc_back.sv
design/four_point_touch_calibration_core.sv
tb/tb_top.sv
